// ===== hw/rtl/wcf_pkg.sv =====
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared constants, types and helpers of the window convolution filter.
// ----------------------------------------------------------------------------
package wcf_pkg;

  localparam int MAX_KERNEL     = 7;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int COEF_FRAC_BITS = 16;

  localparam int COEF_COUNT = MAX_KERNEL * MAX_KERNEL;
  localparam int KW         = $clog2(MAX_KERNEL + 1);
  localparam int SLOT_W     = $clog2(MAX_KERNEL);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                               $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT)) + 1;
  localparam int CFG_W      = 11;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 20;
  localparam int CIDX_W     = 6;
  localparam int KIDX_W     = $clog2(COEF_COUNT);
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(COEF_COUNT);
  localparam int LINE_DEPTH = (2 ** SLOT_W) * MAX_WIDTH;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_DRAIN = 2'd2
  } kind_e;

  localparam logic [1:0] CFG_KERNEL = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [KW-1:0]    n;
    logic [KW-1:0]    half;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } cfg_t;

  typedef struct packed {
    logic              interior;
    logic              last;
    logic [SLOT_W-1:0] top_slot;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  ox;
    logic [COL_W-1:0]  col0;
  } job_t;

  typedef struct packed {
    logic              pix_we;
    logic [SLOT_W-1:0] pix_slot;
    logic [COL_W-1:0]  pix_col;
    logic [PIX_W-1:0]  pix_data;
    logic              coef_we;
    logic [KIDX_W-1:0] coef_idx;
    logic [COEF_W-1:0] coef_data;
  } wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic busy;
  } bstat_t;

  function automatic logic [KW-1:0] eff_n(input logic [2:0] k);
    int n;
    n = int'(k);
    if (n < 3) n = 3;
    if (k[0] == 1'b0 && n == int'(k)) n = n + 1;
    if (n > MAX_KERNEL) n = ((MAX_KERNEL % 2) != 0) ? MAX_KERNEL : MAX_KERNEL - 1;
    return KW'(n);
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int hi);
    int d;
    d = int'(v);
    if (d < 3) d = 3;
    if (d > hi) d = hi;
    return DIM_W'(d);
  endfunction

endpackage

// ===== hw/rtl/wcf_front.sv =====
// ----------------------------------------------------------------------------
// wcf_front
// Accepts requests, tracks raster positions, writes line and coefficient
// storage and queues one job per result.
// ----------------------------------------------------------------------------
module wcf_front import wcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [CIDX_W-1:0] coefficient_index_i,
  input  logic [COEF_W-1:0] coefficient_value_i,
  input  logic [PIX_W-1:0]  pixel_value_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  qstat_t            qstat_i,
  input  bstat_t            bstat_i,
  output logic              push_o,
  output job_t              job_o,
  output wr_t               wr_o,
  output cfg_t              cfg_o
);

  logic [2:0]        kernel_q;
  logic [CFG_W-1:0]  width_q, height_q;
  logic [COL_W-1:0]  in_col_q, in_col_d, ox_q, ox_d;
  logic [DIM_W-1:0]  in_row_q, in_row_d, oy_q, oy_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;

  logic [DIM_W-1:0] half_d, ox_ext;
  logic is_pix, is_load, is_drain, in_done, pix_write, pos_ok, emit, accept;

  assign cfg_o.n    = eff_n(kernel_q);
  assign cfg_o.half = cfg_o.n >> 1;
  assign cfg_o.w    = eff_dim(width_q, MAX_WIDTH);
  assign cfg_o.h    = eff_dim(height_q, MAX_HEIGHT);

  assign half_d = DIM_W'(cfg_o.half);
  assign ox_ext = DIM_W'(ox_q);

  assign is_pix   = (kind_i == KIND_PIXEL);
  assign is_load  = (kind_i == KIND_LOAD);
  assign is_drain = (kind_i == KIND_DRAIN);
  assign in_done  = (in_row_q >= cfg_o.h);
  assign pix_write = is_pix && !in_done;
  assign pos_ok = (in_row_q > half_d) || (in_row_q == half_d && DIM_W'(in_col_q) >= half_d);
  assign emit = (pix_write && pos_ok) || ((is_drain || is_pix) && in_done);

  // storage writes wait until the back end has nothing in flight
  assign in_ready_o = !qstat_i.full &&
                      ((is_load || is_pix) ? (qstat_i.empty && !bstat_i.busy) : 1'b1);
  assign accept = in_valid_i && in_ready_o;
  assign push_o = accept && emit;
  assign cfg_ready_o = 1'b1;

  assign job_o.interior = (oy_q >= half_d) && (oy_q + half_d < cfg_o.h) &&
                          (ox_ext >= half_d) && (ox_ext + half_d < cfg_o.w);
  assign job_o.last = (ox_ext == cfg_o.w - DIM_W'(1)) && (oy_q == cfg_o.h - DIM_W'(1));
  assign job_o.top_slot = (KW'(out_slot_q) >= cfg_o.half) ?
                          SLOT_W'(KW'(out_slot_q) - cfg_o.half) :
                          SLOT_W'(KW'(out_slot_q) + KW'(MAX_KERNEL) - cfg_o.half);
  assign job_o.slot = out_slot_q;
  assign job_o.ox   = ox_q;
  assign job_o.col0 = ox_q - COL_W'(cfg_o.half);

  assign wr_o.pix_we    = accept && pix_write;
  assign wr_o.pix_slot  = in_slot_q;
  assign wr_o.pix_col   = in_col_q;
  assign wr_o.pix_data  = pixel_value_i;
  assign wr_o.coef_we   = accept && is_load && (int'(coefficient_index_i) < COEF_COUNT);
  assign wr_o.coef_idx  = KIDX_W'(coefficient_index_i);
  assign wr_o.coef_data = coefficient_value_i;

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    out_slot_d = out_slot_q;
    if (accept && pix_write) begin
      if (DIM_W'(in_col_q) == cfg_o.w - DIM_W'(1)) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + DIM_W'(1);
        in_slot_d = (in_slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : in_slot_q + SLOT_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end
    if (push_o) begin
      if (job_o.last) begin
        in_col_d   = '0;
        in_row_d   = '0;
        in_slot_d  = '0;
        ox_d       = '0;
        oy_d       = '0;
        out_slot_d = '0;
      end else if (ox_ext == cfg_o.w - DIM_W'(1)) begin
        ox_d       = '0;
        oy_d       = oy_q + DIM_W'(1);
        out_slot_d = (out_slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : out_slot_q + SLOT_W'(1);
      end else begin
        ox_d = ox_q + COL_W'(1);
      end
    end
    // a register write abandons the frame in progress
    if (cfg_valid_i && (cfg_index_i == CFG_KERNEL || cfg_index_i == CFG_WIDTH ||
                        cfg_index_i == CFG_HEIGHT)) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      ox_d       = '0;
      oy_d       = '0;
      out_slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q   <= 3'd3;
      width_q    <= CFG_W'(512);
      height_q   <= CFG_W'(512);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      out_slot_q <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      out_slot_q <= out_slot_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_KERNEL: kernel_q <= cfg_data_i[2:0];
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/wcf_queue.sv =====
// ----------------------------------------------------------------------------
// wcf_queue
// Short job queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
module wcf_queue import wcf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  job_t   job_i,
  input  logic   pop_i,
  output job_t   job_o,
  output qstat_t qstat_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  assign job_o         = entry_q[rptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      if (pop_i)  rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wcf_back.sv =====
// ----------------------------------------------------------------------------
// wcf_back
// Holds line and coefficient storage, walks the window one tap per cycle
// through a multiply-accumulate pipeline and drives the output register.
// ----------------------------------------------------------------------------
module wcf_back import wcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  wr_t              wr_i,
  input  qstat_t           qstat_i,
  input  job_t             job_i,
  output logic             pop_o,
  output bstat_t           bstat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] filtered_pixel_o,
  output logic             saturated_o,
  output logic             last_of_frame_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_TAPS, S_FLUSH, S_EDGE, S_EDGE_WAIT
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [KW-1:0]     r_q, c_q;
  logic [KIDX_W-1:0] k_q;
  logic [SLOT_W-1:0] slot_q;
  logic [COL_W-1:0]  col_q;
  logic              v1_q, v2_q;

  logic [PIX_W-1:0]  line_mem [LINE_DEPTH];
  logic [COEF_W-1:0] coef_mem [COEF_COUNT];
  logic [PIX_W-1:0]  pix_q;
  logic [COEF_W-1:0] coef_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;

  logic [SLOT_W+COL_W-1:0] raddr;
  logic [ACC_W-1:0]        shifted;
  logic                    sat;
  logic [PIX_W-1:0]        sum_pix;
  logic                    last_c, last_r, issue, acc_clr;

  assign pop_o        = (state_q == S_IDLE) && !qstat_i.empty && !out_valid_o;
  assign bstat_o.busy = (state_q != S_IDLE);
  assign issue        = (state_q == S_TAPS);
  assign acc_clr      = pop_o;
  assign last_c       = (c_q == cfg_i.n - KW'(1));
  assign last_r       = (r_q == cfg_i.n - KW'(1));
  assign raddr        = (state_q == S_EDGE) ? {job_q.slot, job_q.ox} : {slot_q, col_q};

  assign shifted = acc_q >> COEF_FRAC_BITS;
  assign sat     = |shifted[ACC_W-1:PIX_W];
  assign sum_pix = sat ? {PIX_W{1'b1}} : shifted[PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.pix_we)  line_mem[{wr_i.pix_slot, wr_i.pix_col}] <= wr_i.pix_data;
    if (wr_i.coef_we) coef_mem[wr_i.coef_idx] <= wr_i.coef_data;
    pix_q  <= line_mem[raddr];
    coef_q <= coef_mem[k_q];
    prod_q <= pix_q * coef_q;
    if (acc_clr)   acc_q <= '0;
    else if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      job_q            <= '0;
      r_q              <= '0;
      c_q              <= '0;
      k_q              <= '0;
      slot_q           <= '0;
      col_q            <= '0;
      v1_q             <= 1'b0;
      v2_q             <= 1'b0;
      out_valid_o      <= 1'b0;
      filtered_pixel_o <= '0;
      saturated_o      <= 1'b0;
      last_of_frame_o  <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            job_q  <= job_i;
            r_q    <= '0;
            c_q    <= '0;
            k_q    <= '0;
            slot_q <= job_i.top_slot;
            col_q  <= job_i.col0;
            state_q <= job_i.interior ? S_TAPS : S_EDGE;
          end
        end
        S_TAPS: begin
          k_q <= k_q + KIDX_W'(1);
          if (last_c) begin
            c_q    <= '0;
            col_q  <= job_q.col0;
            r_q    <= r_q + KW'(1);
            slot_q <= (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + SLOT_W'(1);
            if (last_r) state_q <= S_FLUSH;
          end else begin
            c_q   <= c_q + KW'(1);
            col_q <= col_q + COL_W'(1);
          end
        end
        S_FLUSH: begin
          // wait for the last product to land in the accumulator
          if (!v1_q && !v2_q) begin
            out_valid_o      <= 1'b1;
            filtered_pixel_o <= sum_pix;
            saturated_o      <= sat;
            last_of_frame_o  <= job_q.last;
            state_q          <= S_IDLE;
          end
        end
        S_EDGE: state_q <= S_EDGE_WAIT;
        S_EDGE_WAIT: begin
          out_valid_o      <= 1'b1;
          filtered_pixel_o <= pix_q;
          saturated_o      <= 1'b0;
          last_of_frame_o  <= job_q.last;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/window_convolution_filter.sv =====
// ----------------------------------------------------------------------------
// window_convolution_filter
// N x N convolution over an 8-bit grayscale raster with line storage.
// ----------------------------------------------------------------------------
// Usage: the input channel carries requests of three kinds: coefficient
// loads, raster pixels and drains. Results leave on the output channel in
// raster order, lagging the input by half*W + half pixels; drains flush the
// tail of a frame. The configuration channel sets kernel size, width and
// height; a write restarts the frame and is always ready.
// Timing: a front end tracks positions and queues one job per result in a
// two-entry queue. The back end walks the window one tap per cycle through
// one 8x20 multiplier for an interior result; a border pixel is passed on
// unfiltered from line storage. Loads and pixels are accepted only once the
// back end is idle with an empty queue, since they write the storage it
// reads; drains are accepted while the queue has room.
// Reset clears positions and restores N=3, 512x512; line and coefficient
// storage hold nothing until written. A stalled receiver holds the output
// register, the back end stops, the queue fills and input ready drops.
module window_convolution_filter import wcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [CIDX_W-1:0] coefficient_index_i,
  input  logic [COEF_W-1:0] coefficient_value_i,
  input  logic [PIX_W-1:0]  pixel_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  filtered_pixel_o,
  output logic              saturated_o,
  output logic              last_of_frame_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  qstat_t qstat;
  bstat_t bstat;
  job_t   push_job, head_job;
  wr_t    wr;
  cfg_t   cfg;
  logic   push, pop;

  wcf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .coefficient_index_i,
    .coefficient_value_i, .pixel_value_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i,
    .qstat_i(qstat), .bstat_i(bstat), .push_o(push), .job_o(push_job),
    .wr_o(wr), .cfg_o(cfg)
  );

  wcf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(push_job), .pop_i(pop),
    .job_o(head_job), .qstat_o(qstat)
  );

  wcf_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .wr_i(wr), .qstat_i(qstat), .job_i(head_job),
    .pop_o(pop), .bstat_o(bstat), .out_valid_o, .out_ready_i,
    .filtered_pixel_o, .saturated_o, .last_of_frame_o
  );

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == KIND_LOAD || kind_i == KIND_PIXEL))
      |-> (!bstat.busy && qstat.empty))
    else $error("storage written while back end busy");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !push)
    else $error("job pushed into full queue");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (filtered_pixel_o == {PIX_W{1'b1}}))
    else $error("saturated result not clamped");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!qstat.empty && !out_valid_o))
    else $error("pop from empty queue or into busy output");

endmodule
